// ===== sv/olidl_pkg.sv =====
// Shared constants and types for the ordered list block.
`timescale 1ns / 1ps

package olidl_pkg;

  // Default number of list entries
  localparam int unsigned CAPACITY_DEF = 16;

  // Width of one stored word
  localparam int unsigned WORD_W = 32;

  // Width used for position and index compares (holds 0 .. 127)
  localparam int unsigned CMP_W = 7;

  // Field widths
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned POS_W = 5;
  localparam int unsigned STAT_W = 2;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_LOCATE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STATUS_DONE = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL = 2'd2;

  // Control broadcast to every cell of the row
  typedef struct packed {
    logic              ins;
    logic              del;
    logic              loc;
    logic [CMP_W-1:0]  pm1;
    logic [CMP_W-1:0]  cnt;
    logic [WORD_W-1:0] value;
  } cell_ctl_t;

endpackage

// ===== sv/ordered_list_insert_delete_locate.sv =====
// Top level of the ordered list: cell row, length counter, result register.
//
//  channel  dir  tdata (low bit up)                     tuser
//  s_axis   in   position[4:0], value[36:5], pad to 40  func[1:0]
//  m_axis   out  status[1:0], found_at[6:2],            -
//                length[11:7], pad to 16
//
// Each beat is accepted in S_IDLE and evaluated in S_EVAL: the accept edge shifts
// the cell row and latches the compare flags of every cell, and S_EVAL encodes the
// first match and loads the result register; s_axis_tready stays low in S_EVAL. A result
// waiting on m_axis holds off input until that result beat is taken.
// rst_ni clears the length and all handshake state; the cell words are not
// reset and are read only below the length.
`timescale 1ns / 1ps

module ordered_list_insert_delete_locate #(
  parameter int unsigned CAPACITY = olidl_pkg::CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // position[4:0], value[36:5]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // status[1:0], found_at[6:2], length[11:7]
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CW = olidl_pkg::CMP_W;
  localparam int unsigned WW = olidl_pkg::WORD_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]               count_q, count_d;
  logic [olidl_pkg::STAT_W-1:0]   stat_q, stat_d;
  logic [olidl_pkg::STAT_W-1:0]   out_stat_q;
  logic [olidl_pkg::POS_W-1:0]    out_found_q;
  logic [olidl_pkg::POS_W-1:0]    out_len_q;
  logic                           out_vld_q;

  logic                           in_beat;
  logic [olidl_pkg::FUNC_W-1:0]   func;
  logic [olidl_pkg::POS_W-1:0]    pos;
  logic [WW-1:0]                  value;
  logic [CW-1:0]                  pos_x, cnt_x;
  logic                           ins_bad, ins_full, del_bad;
  olidl_pkg::cell_ctl_t           ctl;
  logic [WW-1:0]                  entry [CAPACITY];
  logic [CAPACITY-1:0]            match;
  logic [olidl_pkg::POS_W-1:0]    found;

  // Unpack the input beat
  assign func  = s_axis_tuser;
  assign pos   = s_axis_tdata[4:0];
  assign value = s_axis_tdata[36:5];

  assign s_axis_tready = (state_q == S_IDLE) && (!out_vld_q || m_axis_tready);
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // Check positions against the current length
  assign pos_x    = CW'(pos);
  assign cnt_x    = CW'(count_q);
  assign ins_bad  = (pos == '0) || (pos_x > cnt_x + CW'(1));
  assign ins_full = (cnt_x == CW'(CAPACITY));
  assign del_bad  = (pos == '0) || (pos_x > cnt_x);

  // Build the broadcast control and the new length and status
  always_comb begin
    ctl       = '0;
    ctl.pm1   = pos_x - CW'(1);
    ctl.cnt   = cnt_x;
    ctl.value = value;
    count_d   = count_q;
    stat_d    = olidl_pkg::STATUS_DONE;
    if (in_beat) begin
      case (func)
        olidl_pkg::FUNC_LOCATE: begin
          ctl.loc = 1'b1;
        end
        olidl_pkg::FUNC_INSERT: begin
          if (ins_bad) begin
            stat_d = olidl_pkg::STATUS_RANGE;
          end else if (ins_full) begin
            stat_d = olidl_pkg::STATUS_FULL;
          end else begin
            ctl.ins = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
        end
        olidl_pkg::FUNC_DELETE: begin
          if (del_bad) begin
            stat_d = olidl_pkg::STATUS_RANGE;
          end else begin
            ctl.del = 1'b1;
            count_d = count_q - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Row of cells wired to their neighbors; the first takes the new word on the left, the last its own word on the right
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = value;
    end else begin : g_mid_l
      assign left_w = entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = entry[g];
    end else begin : g_mid_r
      assign right_w = entry[g+1];
    end
    olidl_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .left_i (left_w),
      .right_i(right_w),
      .entry_o(entry[g]),
      .match_o(match[g])
    );
  end

  // Encode the first match latched by the cells
  olidl_prio #(
    .CAPACITY(CAPACITY)
  ) u_prio (
    .match_i(match),
    .found_o(found)
  );

  // Sequence: accept, then evaluate
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == S_EVAL) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Hold the pending status, then load the result register
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      stat_q <= stat_d;
    end
    if (state_q == S_EVAL) begin
      out_stat_q  <= stat_q;
      out_found_q <= found;
      out_len_q   <= olidl_pkg::POS_W'(count_q);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, out_len_q, out_found_q, out_stat_q};

endmodule

// ===== sv/olidl_cell.sv =====
// One list cell: holds an entry, shifts with its neighbors and flags a match.
`timescale 1ns / 1ps

module olidl_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  olidl_pkg::cell_ctl_t                ctl_i,
  input  logic [olidl_pkg::WORD_W-1:0]        left_i,
  input  logic [olidl_pkg::WORD_W-1:0]        right_i,
  output logic [olidl_pkg::WORD_W-1:0]        entry_o,
  output logic                                match_o
);

  localparam logic [olidl_pkg::CMP_W-1:0] IdxC = olidl_pkg::CMP_W'(IDX);

  logic [olidl_pkg::WORD_W-1:0] entry_q, entry_d;
  logic                         match_q, match_d;

  // Pick the next entry: keep it, take the new word, take the left word, or take the right word
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins) begin
      if (IdxC == ctl_i.pm1) begin
        entry_d = ctl_i.value;
      end else if (IdxC > ctl_i.pm1) begin
        entry_d = left_i;
      end
    end else if (ctl_i.del) begin
      if (IdxC >= ctl_i.pm1) begin
        entry_d = right_i;
      end
    end
  end

  // On a locate, flag a held entry below the length equal to the searched word
  assign match_d = ctl_i.loc && (IdxC < ctl_i.cnt) && (entry_q == ctl_i.value);

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

// ===== sv/olidl_prio.sv =====
// Priority encoder: lowest matching cell as a 1-based position, 0 if none.
`timescale 1ns / 1ps

module olidl_prio #(
  parameter int unsigned CAPACITY = olidl_pkg::CAPACITY_DEF
) (
  input  logic [CAPACITY-1:0]           match_i,
  output logic [olidl_pkg::POS_W-1:0]   found_o
);

  // Scan from the top so the lowest match wins
  always_comb begin
    found_o = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_i[i]) begin
        found_o = olidl_pkg::POS_W'(i + 1);
      end
    end
  end

endmodule

// ===== verif/tb_ordered_list_insert_delete_locate.sv =====
// Self-checking testbench for the ordered list: directed cases, random mix, stream stalls.
`timescale 1ns / 1ps

module tb_ordered_list_insert_delete_locate;

  localparam int unsigned LIST_CAP = olidl_pkg::CAPACITY_DEF;
  localparam logic [olidl_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int unsigned DRAIN_LIMIT = 10000;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam longint unsigned TIMEOUT_NS = 5_000_000;

  typedef struct packed {
    logic [olidl_pkg::STAT_W-1:0] status;
    logic [olidl_pkg::POS_W-1:0]  found_at;
    logic [olidl_pkg::POS_W-1:0]  length;
  } list_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // position[4:0], value[36:5]
  logic [1:0]  s_axis_tuser;   // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // status[1:0], found_at[6:2], length[11:7]

  // Predicted list contents and expected results in arrival order
  logic [olidl_pkg::WORD_W-1:0] list_words [LIST_CAP];
  int unsigned                  list_len;
  list_result_t                 pending[$];
  int unsigned                  fail_count;
  bit                           gaps_on;
  int unsigned                  sink_hold;

  ordered_list_insert_delete_locate #(
    .CAPACITY(LIST_CAP)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Apply one operation to the predicted list and return its result
  function automatic list_result_t apply_list_op(input logic [olidl_pkg::FUNC_W-1:0] op,
                                                 input logic [olidl_pkg::POS_W-1:0] pos,
                                                 input logic [olidl_pkg::WORD_W-1:0] word);
    list_result_t r;
    int unsigned  p;
    int unsigned  k;
    r.status = olidl_pkg::STATUS_DONE;
    r.found_at = '0;
    p = pos;
    case (op)
      olidl_pkg::FUNC_LOCATE: begin
        for (k = 0; k < list_len; k++) begin
          if (r.found_at == 0 && list_words[k] == word) begin
            r.found_at = olidl_pkg::POS_W'(k + 1);
          end
        end
      end
      olidl_pkg::FUNC_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          r.status = olidl_pkg::STATUS_RANGE;
        end else if (list_len >= LIST_CAP) begin
          r.status = olidl_pkg::STATUS_FULL;
        end else begin
          for (k = list_len; k >= p; k--) list_words[k] = list_words[k-1];
          list_words[p-1] = word;
          list_len++;
        end
      end
      olidl_pkg::FUNC_DELETE: begin
        if (p < 1 || p > list_len) begin
          r.status = olidl_pkg::STATUS_RANGE;
        end else begin
          for (k = p; k < list_len; k++) list_words[k-1] = list_words[k];
          list_len--;
        end
      end
      default: ;
    endcase
    r.length = olidl_pkg::POS_W'(list_len);
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Words biased toward duplicates and extremes
  function automatic logic [olidl_pkg::WORD_W-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return olidl_pkg::WORD_W'($urandom_range(0, 7));
    if (r < 40) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'hffff_ffff;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom;
  endfunction

  // Hold the beat until accepted, then record its expected result
  task automatic send_beat(input logic [olidl_pkg::FUNC_W-1:0] op,
                           input logic [olidl_pkg::POS_W-1:0] pos,
                           input logic [olidl_pkg::WORD_W-1:0] word);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, word, pos};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    pending.push_back(apply_list_op(op, pos, word));
  endtask

  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    while (pending.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending.size() != 0) begin
      $error("%0d results never arrived", pending.size());
      fail_count++;
    end
  endtask

  // Result sink: random stalls on tready
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
      sink_hold = pick_gap();
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending.pop_front();
        if (m_axis_tdata[1:0] !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, m_axis_tdata[1:0]);
          fail_count++;
        end
        if (m_axis_tdata[6:2] !== want.found_at) begin
          $error("found_at mismatch: expected %0d, got %0d", want.found_at, m_axis_tdata[6:2]);
          fail_count++;
        end
        if (m_axis_tdata[11:7] !== want.length) begin
          $error("length mismatch: expected %0d, got %0d", want.length, m_axis_tdata[11:7]);
          fail_count++;
        end
      end
    end
  end

  // Operations on an empty list and unused func code
  task automatic test_empty_list();
    send_beat(olidl_pkg::FUNC_DELETE, 5'd1, 32'd0);
    send_beat(olidl_pkg::FUNC_INSERT, 5'd0, 32'd5);
    send_beat(olidl_pkg::FUNC_INSERT, 5'd2, 32'd5);
    send_beat(olidl_pkg::FUNC_LOCATE, 5'd31, 32'd0);
    send_beat(FUNC_SPARE, 5'd7, $urandom);
  endtask

  // Fill at head, tail and middle; then bad position ahead of full check
  task automatic test_fill_to_capacity();
    logic [olidl_pkg::WORD_W-1:0] words [16];
    logic [olidl_pkg::POS_W-1:0]  pos;
    int unsigned                  i;
    words = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
              32'h5555_5555, 32'haaaa_aaaa, 32'd7, 32'd7, 32'd1, 32'd7,
              32'h0000_ffff, 32'hffff_0000, 32'd3, 32'd7, 32'h8000_0001, 32'h7fff_fffe};
    for (i = 0; i < LIST_CAP; i++) begin
      case (i % 3)
        0: pos = 5'd1;
        1: pos = olidl_pkg::POS_W'(list_len + 1);
        default: pos = olidl_pkg::POS_W'(list_len / 2 + 1);
      endcase
      send_beat(olidl_pkg::FUNC_INSERT, pos, words[i % 16]);
    end
    send_beat(olidl_pkg::FUNC_INSERT, olidl_pkg::POS_W'(LIST_CAP + 2), 32'd9);
    send_beat(olidl_pkg::FUNC_INSERT, 5'd1, 32'd9);
  endtask

  // First of several matches, absent word, extreme word
  task automatic test_locate();
    send_beat(olidl_pkg::FUNC_LOCATE, 5'd0, 32'd7);
    send_beat(olidl_pkg::FUNC_LOCATE, 5'd16, 32'h1234_5678);
    send_beat(olidl_pkg::FUNC_LOCATE, 5'd31, 32'h8000_0000);
  endtask

  // Bad delete positions, then last and first entries
  task automatic test_delete();
    send_beat(olidl_pkg::FUNC_DELETE, 5'd0, 32'd0);
    send_beat(olidl_pkg::FUNC_DELETE, olidl_pkg::POS_W'(list_len + 1), 32'd0);
    send_beat(olidl_pkg::FUNC_DELETE, olidl_pkg::POS_W'(list_len), 32'd0);
    send_beat(olidl_pkg::FUNC_DELETE, 5'd1, 32'd0);
  endtask

  // Mostly legal positions, swinging between full and empty, with some noise
  task automatic test_random_mix(input int unsigned n_items);
    bit                           grow;
    int unsigned                  i;
    int unsigned                  r;
    logic [olidl_pkg::WORD_W-1:0] word;
    grow = 1'b1;
    for (i = 0; i < n_items; i++) begin
      if (list_len == 0) grow = 1'b1;
      else if (list_len == LIST_CAP && $urandom_range(0, 3) == 0) grow = 1'b0;
      else if ($urandom_range(0, 79) == 0) grow = ~grow;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_beat(olidl_pkg::FUNC_W'($urandom_range(0, 3)), olidl_pkg::POS_W'($urandom),
                  $urandom);
      end else if (r < 35) begin
        if (list_len > 0 && $urandom_range(0, 1) == 1)
          word = list_words[$urandom_range(0, list_len - 1)];
        else
          word = pick_word();
        send_beat(olidl_pkg::FUNC_LOCATE, olidl_pkg::POS_W'($urandom), word);
      end else if ($urandom_range(0, 99) < (grow ? 70 : 30)) begin
        send_beat(olidl_pkg::FUNC_INSERT,
                  olidl_pkg::POS_W'($urandom_range(1, list_len + 1)), pick_word());
      end else begin
        send_beat(olidl_pkg::FUNC_DELETE,
                  olidl_pkg::POS_W'($urandom_range(1, list_len > 0 ? list_len : 1)),
                  $urandom);
      end
    end
  endtask

  // Full-rate stretch without gaps on either side
  task automatic test_back_to_back();
    gaps_on = 1'b0;
    test_random_mix(150);
    gaps_on = 1'b1;
  endtask

  // Hold off the sender until every outstanding result is back, then run a further random mix
  task automatic test_drain_pause();
    s_axis_tvalid <= 1'b0;
    wait_drained();
    test_random_mix(650);
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    list_len = 0;
    fail_count = 0;
    gaps_on = 1'b1;
    sink_hold = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_list();
    test_fill_to_capacity();
    test_locate();
    test_delete();
    test_random_mix(700);
    test_back_to_back();
    test_drain_pause();

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
